/* design/mccd_pkg.sv */
// types, codes and constant tables shared by the control-change capture and dump block
// no dependencies; compiled first
`timescale 1ns / 1ps

package mccd_pkg;

	typedef enum logic [1:0] {
		ACT_MIDI = 2'd0,
		ACT_SLOT = 2'd1,
		ACT_DUMP = 2'd2
	} action_t;

	typedef enum logic [1:0] {
		PH_IDLE  = 2'd0,
		PH_VALUE = 2'd1,
		PH_SKIP  = 2'd2
	} phase_t;

	typedef enum logic [1:0] {
		DS_IDLE  = 2'd0,
		DS_HEAD  = 2'd1,
		DS_SLOTS = 2'd2,
		DS_TAIL  = 2'd3
	} dump_state_t;

	typedef enum logic [1:0] {
		CFG_OUT_CHANNEL     = 2'd0,
		CFG_MARKER_NOTE     = 2'd1,
		CFG_MARKER_VELOCITY = 2'd2
	} cfg_index_t;

	localparam logic [7:0] STATUS_MIN   = 8'h80;
	localparam logic [3:0] NIB_SYSTEM   = 4'hF;
	localparam logic [3:0] NIB_CC       = 4'hB;
	localparam logic [3:0] NIB_NOTE_ON  = 4'h9;
	localparam logic [3:0] NIB_NOTE_OFF = 4'h8;
	localparam logic [7:0] BYTE_ZERO    = 8'h00;

	localparam logic [3:0] RST_OUT_CHANNEL     = 4'd2;
	localparam logic [6:0] RST_MARKER_NOTE     = 7'd80;
	localparam logic [6:0] RST_MARKER_VELOCITY = 7'd80;

	typedef struct packed {
		logic [1:0] action;
		logic [7:0] data_byte;
		logic [4:0] slot_index;
	} item_t;

	typedef struct packed {
		logic [3:0] out_channel;
		logic [6:0] marker_note;
		logic [6:0] marker_velocity;
	} cfg_t;

	// fixed controller number of each slot; slots past the seventeenth count up from 102, but slot 31 maps to 0
	function automatic logic [7:0] slot_ctrl(input logic [4:0] idx);
		logic [7:0] r;
		case (idx)
			5'd0:  r = 8'd17;
			5'd1:  r = 8'd18;
			5'd2:  r = 8'd19;
			5'd3:  r = 8'd79;
			5'd4:  r = 8'd75;
			5'd5:  r = 8'd72;
			5'd6:  r = 8'd83;
			5'd7:  r = 8'd73;
			5'd8:  r = 8'd71;
			5'd9:  r = 8'd74;
			5'd10: r = 8'd20;
			5'd11: r = 8'd76;
			5'd12: r = 8'd77;
			5'd13: r = 8'd78;
			5'd14: r = 8'd80;
			5'd15: r = 8'd82;
			5'd16: r = 8'd81;
			5'd31: r = 8'd0;
			default: r = 8'd85 + {3'd0, idx};
		endcase
		return r;
	endfunction

	function automatic logic [7:0] slot_default(input logic [4:0] idx);
		logic [7:0] r;
		case (idx)
			5'd0:  r = 8'd127;
			5'd3:  r = 8'd120;
			5'd4:  r = 8'd10;
			5'd6:  r = 8'd64;
			5'd8:  r = 8'd10;
			5'd9:  r = 8'd100;
			5'd11: r = 8'd64;
			5'd13: r = 8'd64;
			5'd15: r = 8'd10;
			5'd16: r = 8'd10;
			default: r = 8'd0;
		endcase
		return r;
	endfunction

endpackage

/* design/mccd_cmd_if.sv */
// command channel: midi bytes, slot loads and dump requests
// no dependencies
`timescale 1ns / 1ps

interface mccd_cmd_if;
	logic       valid;
	logic       ready;
	logic [1:0] action;
	logic [7:0] data_byte;
	logic [4:0] slot_index;

	modport source (output valid, action, data_byte, slot_index, input ready);
	modport sink   (input valid, action, data_byte, slot_index, output ready);
endinterface

/* design/mccd_byte_if.sv */
// dump byte channel
// no dependencies
`timescale 1ns / 1ps

interface mccd_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       last;

	modport source (output valid, out_byte, last, input ready);
	modport sink   (input valid, out_byte, last, output ready);
endinterface

/* design/mccd_parse.sv */
// running-status parser and slot value store
// depends on mccd_pkg
`timescale 1ns / 1ps

module mccd_parse #(
	parameter int SLOT_COUNT = 17,
	parameter int SLOT_W     = 5
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	input  mccd_pkg::item_t     item,
	input  logic [SLOT_W-1:0]   rd_idx,
	output logic [7:0]          rd_value
);
	import mccd_pkg::*;

	logic [7:0] running_status_q;
	phase_t     phase_q;
	logic [7:0] pending_ctrl_q;
	logic [7:0] slot_q [SLOT_COUNT];

	logic is_midi;
	logic slot_in_range;

	assign is_midi       = item_valid && (item.action == ACT_MIDI);
	assign slot_in_range = {1'b0, item.slot_index} < 6'(SLOT_COUNT);
	assign rd_value      = slot_q[rd_idx];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_status_q <= 8'd0;
			phase_q          <= PH_IDLE;
		end else if (is_midi) begin
			case (phase_q)
				PH_VALUE, PH_SKIP: phase_q <= PH_IDLE;
				default: begin
					if (item.data_byte >= STATUS_MIN) begin
						running_status_q <= item.data_byte;
					end else if (running_status_q[7:4] == NIB_CC) begin
						phase_q <= PH_VALUE;
					end else if (running_status_q[7:4] != NIB_SYSTEM) begin
						phase_q <= PH_SKIP;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (is_midi && phase_q == PH_IDLE && item.data_byte < STATUS_MIN
				&& running_status_q[7:4] == NIB_CC) begin
			pending_ctrl_q <= item.data_byte;
		end
	end

	// every slot compares its own controller number in parallel
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SLOT_COUNT; i++) begin
				slot_q[i] <= slot_default(5'(i));
			end
		end else if (item_valid) begin
			if (item.action == ACT_MIDI && phase_q == PH_VALUE) begin
				for (int i = 0; i < SLOT_COUNT; i++) begin
					if (slot_ctrl(5'(i)) == pending_ctrl_q) begin
						slot_q[i] <= item.data_byte;
					end
				end
			end else if (item.action == ACT_SLOT && slot_in_range) begin
				slot_q[item.slot_index[SLOT_W-1:0]] <= item.data_byte;
			end
		end
	end

endmodule

/* design/mccd_dump.sv */
// dump sequencer: note-on, one control change per slot, note-off, with output register
// depends on mccd_pkg
`timescale 1ns / 1ps

module mccd_dump #(
	parameter int SLOT_COUNT = 17,
	parameter int SLOT_W     = 5
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  mccd_pkg::cfg_t    cfg,
	output logic              busy,
	output logic [SLOT_W-1:0] rd_idx,
	input  logic [7:0]        rd_value,
	mccd_byte_if.source       dump
);
	import mccd_pkg::*;

	dump_state_t       state_q, state_d;
	logic [1:0]        sub_q, sub_d;
	logic [SLOT_W-1:0] slot_idx_q, slot_idx_d;
	logic              out_valid_q;
	logic [7:0]        out_byte_q;
	logic              out_last_q;

	logic              out_free;
	logic              emit;
	logic [7:0]        byte_d;
	logic              last_d;

	assign out_free = !out_valid_q || dump.ready;
	assign busy     = (state_q != DS_IDLE);
	assign rd_idx   = slot_idx_q;

	always_comb begin
		state_d    = state_q;
		sub_d      = sub_q;
		slot_idx_d = slot_idx_q;
		emit       = 1'b0;
		byte_d     = BYTE_ZERO;
		last_d     = 1'b0;
		case (state_q)
			DS_IDLE: begin
				if (start) begin
					state_d    = DS_HEAD;
					sub_d      = 2'd0;
					slot_idx_d = '0;
				end
			end
			DS_HEAD: begin
				emit = 1'b1;
				case (sub_q)
					2'd0:    byte_d = {NIB_NOTE_ON, cfg.out_channel};
					2'd1:    byte_d = {1'b0, cfg.marker_note};
					default: byte_d = {1'b0, cfg.marker_velocity};
				endcase
			end
			DS_SLOTS: begin
				emit = 1'b1;
				case (sub_q)
					2'd0:    byte_d = {NIB_CC, cfg.out_channel};
					2'd1:    byte_d = slot_ctrl(5'(slot_idx_q));
					default: byte_d = rd_value;
				endcase
			end
			DS_TAIL: begin
				emit = 1'b1;
				case (sub_q)
					2'd0:    byte_d = {NIB_NOTE_OFF, cfg.out_channel};
					2'd1:    byte_d = {1'b0, cfg.marker_note};
					default: begin
						byte_d = BYTE_ZERO;
						last_d = 1'b1;
					end
				endcase
			end
			default: state_d = DS_IDLE;
		endcase

		// step through each three-byte message, then on to the next message
		if (emit && out_free) begin
			if (sub_q == 2'd2) begin
				sub_d = 2'd0;
				case (state_q)
					DS_HEAD: state_d = DS_SLOTS;
					DS_SLOTS: begin
						if (slot_idx_q == SLOT_W'(SLOT_COUNT - 1)) begin
							state_d = DS_TAIL;
						end else begin
							slot_idx_d = slot_idx_q + SLOT_W'(1);
						end
					end
					default: state_d = DS_IDLE;
				endcase
			end else begin
				sub_d = sub_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= DS_IDLE;
			sub_q       <= 2'd0;
			slot_idx_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q    <= state_d;
			sub_q      <= sub_d;
			slot_idx_q <= slot_idx_d;
			if (out_free) begin
				out_valid_q <= emit;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			out_byte_q <= byte_d;
			out_last_q <= last_d;
		end
	end

	assign dump.valid    = out_valid_q;
	assign dump.out_byte = out_byte_q;
	assign dump.last     = out_last_q;

endmodule

/* design/midi_cc_capture_and_dump.sv */
// top level: command input register, config registers, parser and dump sequencer
// depends on mccd_pkg, mccd_cmd_if, mccd_byte_if, mccd_parse, mccd_dump
//
//  channel  | role   | payload                          | handshake
//  cmd      | sink   | action, data_byte, slot_index    | valid / ready
//  dump     | source | out_byte, last                   | valid / ready
//  cfg      | write  | cfg_index, cfg_data              | cfg_we, no wait
//
// midi bytes and slot loads can follow back to back;
// a command is registered, then parsed and applied to the slots on the next edge.
// a dump holds cmd.ready low from its acceptance until its last byte sits in the
// output register: 3*SLOT_COUNT+6 byte transactions, one per cycle while dump.ready is high.
// reset returns running status to 0, the parser to idle and every slot to its default.
`timescale 1ns / 1ps

module midi_cc_capture_and_dump #(
	parameter int SLOT_COUNT = 17
) (
	input  logic       clk,
	input  logic       arst_n,
	mccd_cmd_if.sink   cmd,
	mccd_byte_if.source dump,
	input  logic       cfg_we,
	input  logic [1:0] cfg_index,
	input  logic [6:0] cfg_data
);
	import mccd_pkg::*;

	localparam int SLOT_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

	logic              valid_s1;
	item_t             item_s1;
	cfg_t              cfg_q;
	logic              dump_busy;
	logic              dump_start;
	logic              cmd_accept;
	logic [SLOT_W-1:0] rd_idx;
	logic [7:0]        rd_value;

	assign dump_start = valid_s1 && (item_s1.action == ACT_DUMP);
	assign cmd.ready  = !dump_start && !dump_busy;
	assign cmd_accept = cmd.valid && cmd.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= cmd_accept;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_accept) begin
			item_s1.action     <= cmd.action;
			item_s1.data_byte  <= cmd.data_byte;
			item_s1.slot_index <= cmd.slot_index;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.out_channel     <= RST_OUT_CHANNEL;
			cfg_q.marker_note     <= RST_MARKER_NOTE;
			cfg_q.marker_velocity <= RST_MARKER_VELOCITY;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_OUT_CHANNEL:     cfg_q.out_channel     <= cfg_data[3:0];
				CFG_MARKER_NOTE:     cfg_q.marker_note     <= cfg_data;
				CFG_MARKER_VELOCITY: cfg_q.marker_velocity <= cfg_data;
				default: ;
			endcase
		end
	end

	mccd_parse #(
		.SLOT_COUNT (SLOT_COUNT),
		.SLOT_W     (SLOT_W)
	) u_parse (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (valid_s1),
		.item       (item_s1),
		.rd_idx     (rd_idx),
		.rd_value   (rd_value)
	);

	mccd_dump #(
		.SLOT_COUNT (SLOT_COUNT),
		.SLOT_W     (SLOT_W)
	) u_dump (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (dump_start),
		.cfg      (cfg_q),
		.busy     (dump_busy),
		.rd_idx   (rd_idx),
		.rd_value (rd_value),
		.dump     (dump)
	);

endmodule

/* design/mccd_checker.sv */
// port-level checks for the control-change capture and dump block, bound to the top level
// depends on mccd_pkg and midi_cc_capture_and_dump
`timescale 1ns / 1ps

module mccd_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       cmd_valid,
	input logic       cmd_ready,
	input logic [1:0] cmd_action,
	input logic       dump_valid,
	input logic       dump_ready,
	input logic [7:0] dump_out_byte,
	input logic       dump_last
);
	import mccd_pkg::*;

	// a stalled byte must not change
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		dump_valid && !dump_ready |=> dump_valid && $stable(dump_out_byte) && $stable(dump_last))
		else $error("dump byte changed while stalled");

	// a dump blocks new commands while it gets under way
	a_dump_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_ready && cmd_action == ACT_DUMP |=> !cmd_ready ##1 !cmd_ready)
		else $error("command accepted during dump start");

	// the closing note-off carries zero velocity
	a_last_zero: assert property (@(posedge clk) disable iff (!arst_n)
		dump_valid && dump_last |-> dump_out_byte == BYTE_ZERO)
		else $error("last dump byte not zero");

	// a byte under way never shows up while a dump is only just accepted
	a_no_early_byte: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_ready && cmd_action == ACT_DUMP && !dump_valid |=> !dump_valid)
		else $error("dump byte appeared before the request was registered");

endmodule

bind midi_cc_capture_and_dump mccd_checker u_mccd_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.cmd_valid     (cmd.valid),
	.cmd_ready     (cmd.ready),
	.cmd_action    (cmd.action),
	.dump_valid    (dump.valid),
	.dump_ready    (dump.ready),
	.dump_out_byte (dump.out_byte),
	.dump_last     (dump.last)
);
